@@ hdl/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, constants and width helpers for the rotation matrix to
// quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int NUM_W         = 18;
    localparam int QUO_BITS      = 17;
    localparam int MID_DEPTH     = 4;
    localparam int OUT_DEPTH     = 2;

    typedef struct packed {
        logic signed [15:0] read_x;
        logic signed [15:0] read_y;
        logic signed [15:0] read_z;
        logic signed [15:0] phase_x;
        logic signed [15:0] phase_y;
        logic signed [15:0] phase_z;
        logic signed [15:0] slice_x;
        logic signed [15:0] slice_y;
        logic signed [15:0] slice_z;
    } rmq_in_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic               handedness_flipped;
        logic               invalid;
    } rmq_out_t;

    typedef enum logic [1:0] {
        SLOT_X = 2'd0,
        SLOT_Y = 2'd1,
        SLOT_Z = 2'd2,
        SLOT_W = 2'd3
    } rmq_slot_t;

    typedef struct packed {
        rmq_slot_t slot;
        logic      neg;
        logic      flip;
        logic      bad;
    } rmq_ctrl_t;

    function automatic int rad_width(input int frac_bits);
        return ((frac_bits > 17) ? frac_bits : 17) + 3;
    endfunction

endpackage

@@ hdl/rmq_fifo.sv @@
// ----------------------------------------------------------------------------
// rmq_fifo
// Small register queue with count based full and empty flags.
// ----------------------------------------------------------------------------
module rmq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

endmodule

@@ hdl/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front
// Determinant sign, handedness fix and case selection. Produces the radicand,
// three numerators and control for the root and divide pipeline.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int RAD_W     = rmq_pkg::rad_width(FRAC_BITS)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  rmq_pkg::rmq_in_t                        item,
    output logic                                    job_push,
    input  logic                                    job_full,
    output logic signed [RAD_W-1:0]                 job_rad,
    output logic [2:0][rmq_pkg::NUM_W-1:0]          job_num,
    output rmq_pkg::rmq_ctrl_t                      job_ctrl
);
    import rmq_pkg::*;

    localparam logic signed [RAD_W-1:0] ONE = RAD_W'(1) << FRAC_BITS;
    localparam longint TRACE_MIN_L = (longint'(1) << FRAC_BITS) / 100000;
    localparam logic signed [RAD_W-1:0] TRACE_MIN = RAD_W'(TRACE_MIN_L);

    logic                     fen;
    logic                     a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    rmq_in_t                  a_r_reg, b_r_reg, c_r_reg;
    logic signed [31:0]       a_p_reg [6];
    logic signed [47:0]       b_t_reg [6];
    logic signed [50:0]       det;
    logic                     c_flip_reg;
    logic signed [RAD_W-1:0]  d_rad_reg, rad_next;
    logic [2:0][NUM_W-1:0]    d_num_reg, num_next;
    rmq_ctrl_t                d_ctrl_reg, ctrl_next;

    logic signed [16:0]       s13, s23, s33;
    logic signed [RAD_W-1:0]  e11, e22, e33, tr, diff1, diff2, diff3;
    logic signed [NUM_W-1:0]  n_zy, n_xz, n_yx, n_yxp, n_xzp, n_zyp;

    assign fen      = !(d_vld_reg && job_full);
    assign full     = !fen;
    assign job_push = d_vld_reg && fen;
    assign job_rad  = d_rad_reg;
    assign job_num  = d_num_reg;
    assign job_ctrl = d_ctrl_reg;

    assign det = 51'(b_t_reg[0]) + 51'(b_t_reg[1]) + 51'(b_t_reg[2])
               - 51'(b_t_reg[3]) - 51'(b_t_reg[4]) - 51'(b_t_reg[5]);

    always_comb
    begin
        s13 = c_flip_reg ? -17'(c_r_reg.slice_x) : 17'(c_r_reg.slice_x);
        s23 = c_flip_reg ? -17'(c_r_reg.slice_y) : 17'(c_r_reg.slice_y);
        s33 = c_flip_reg ? -17'(c_r_reg.slice_z) : 17'(c_r_reg.slice_z);
        e11 = RAD_W'(c_r_reg.read_x);
        e22 = RAD_W'(c_r_reg.phase_y);
        e33 = RAD_W'(s33);
        tr    = ONE + e11 + e22 + e33;
        diff1 = e11 - e22 - e33;
        diff2 = e22 - e11 - e33;
        diff3 = e33 - e11 - e22;
        n_zy  = NUM_W'(c_r_reg.phase_z) - NUM_W'(s23);
        n_xz  = NUM_W'(s13) - NUM_W'(c_r_reg.read_z);
        n_yx  = NUM_W'(c_r_reg.read_y) - NUM_W'(c_r_reg.phase_x);
        n_yxp = NUM_W'(c_r_reg.read_y) + NUM_W'(c_r_reg.phase_x);
        n_xzp = NUM_W'(c_r_reg.read_z) + NUM_W'(s13);
        n_zyp = NUM_W'(c_r_reg.phase_z) + NUM_W'(s23);

        ctrl_next.flip = c_flip_reg;
        ctrl_next.bad  = 1'b0;
        ctrl_next.neg  = 1'b0;
        if (tr > TRACE_MIN)
        begin
            rad_next       = tr;
            num_next       = {n_yx, n_xz, n_zy};
            ctrl_next.slot = SLOT_W;
        end
        else if (diff1 > 0)
        begin
            rad_next       = ONE + diff1;
            num_next       = {n_zy, n_xzp, n_yxp};
            ctrl_next.slot = SLOT_X;
        end
        else if (diff2 > 0)
        begin
            rad_next       = ONE + diff2;
            num_next       = {n_xz, n_zyp, n_yxp};
            ctrl_next.slot = SLOT_Y;
            ctrl_next.neg  = n_yxp[NUM_W-1];
        end
        else
        begin
            rad_next       = ONE + diff3;
            num_next       = {n_yx, n_zyp, n_xzp};
            ctrl_next.slot = SLOT_Z;
            ctrl_next.bad  = (rad_next <= 0);
            ctrl_next.neg  = !ctrl_next.bad && n_xzp[NUM_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (fen)
        begin
            a_vld_reg <= push;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            a_r_reg    <= item;
            a_p_reg[0] <= item.read_x * item.phase_y;
            a_p_reg[1] <= item.phase_x * item.slice_y;
            a_p_reg[2] <= item.read_y * item.phase_z;
            a_p_reg[3] <= item.slice_x * item.phase_y;
            a_p_reg[4] <= item.phase_x * item.read_y;
            a_p_reg[5] <= item.read_x * item.slice_y;
            b_r_reg    <= a_r_reg;
            b_t_reg[0] <= a_p_reg[0] * a_r_reg.slice_z;
            b_t_reg[1] <= a_p_reg[1] * a_r_reg.read_z;
            b_t_reg[2] <= a_p_reg[2] * a_r_reg.slice_x;
            b_t_reg[3] <= a_p_reg[3] * a_r_reg.read_z;
            b_t_reg[4] <= a_p_reg[4] * a_r_reg.slice_z;
            b_t_reg[5] <= a_p_reg[5] * a_r_reg.phase_z;
            c_r_reg    <= b_r_reg;
            c_flip_reg <= det[50];
            d_rad_reg  <= rad_next;
            d_num_reg  <= num_next;
            d_ctrl_reg <= ctrl_next;
        end
    end

endmodule

@@ hdl/rmq_back.sv @@
// ----------------------------------------------------------------------------
// rmq_back
// Bit per stage square root, three bit per stage rounding dividers, sign fix
// and saturation.
// ----------------------------------------------------------------------------
module rmq_back #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int RAD_W     = rmq_pkg::rad_width(FRAC_BITS)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    job_empty,
    output logic                                    job_pop,
    input  logic signed [RAD_W-1:0]                 job_rad,
    input  logic [2:0][rmq_pkg::NUM_W-1:0]          job_num,
    input  rmq_pkg::rmq_ctrl_t                      job_ctrl,
    output logic                                    res_push,
    input  logic                                    res_full,
    output rmq_pkg::rmq_out_t                       res
);
    import rmq_pkg::*;

    localparam int VW = RAD_W - 1 + FRAC_BITS;
    localparam int QW = (VW + 1) / 2;
    localparam int SW = 2 * QW + 2;
    localparam int QB = QUO_BITS;
    localparam int DW = NUM_W + FRAC_BITS + 1;
    localparam int CW = ((DW > QW + 1 + QB) ? DW : QW + 1 + QB) + 1;
    localparam int MW = (QW > QB) ? QW : QB;

    typedef struct packed {
        logic [SW-1:0]         rem;
        logic [QW-1:0]         root;
        logic [2:0][NUM_W-1:0] num;
        rmq_ctrl_t             ctrl;
    } sq_t;

    typedef struct packed {
        logic [2:0][CW-1:0]    rem;
        logic [2:0][QB-1:0]    quo;
        logic [2:0]            ovf;
        logic [2:0]            sgn;
        logic [QW:0]           d;
        logic [QW-1:0]         half;
        rmq_ctrl_t             ctrl;
    } dv_t;

    function automatic logic [15:0] sat16(input logic [MW-1:0] mag, input logic sgn,
                                          input logic ovf);
        logic big;
        big = ovf || (sgn ? (mag > MW'(32768)) : (mag > MW'(32767)));
        if (big)
        begin
            return sgn ? 16'h8000 : 16'h7fff;
        end
        return sgn ? (~mag[15:0] + 16'd1) : mag[15:0];
    endfunction

    logic       ben;
    sq_t        sq_in;
    sq_t        sq_reg [QW];
    logic       sq_vld [QW];
    dv_t        dv_in;
    dv_t        dv_reg [QB+1];
    logic       dv_vld [QB+1];
    dv_t        last;
    logic [15:0] cv [3];
    logic [15:0] rv;

    assign ben     = !(dv_vld[QB] && res_full);
    assign job_pop = ben && !job_empty;

    always_comb
    begin
        sq_in.rem  = job_ctrl.bad ? (SW'(1) << FRAC_BITS)
                                  : (SW'(job_rad) << FRAC_BITS);
        sq_in.root = '0;
        sq_in.num  = job_num;
        sq_in.ctrl = job_ctrl;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_sq
        localparam int B = QW - 1 - k;
        sq_t           prev, nxt;
        logic          pv;
        logic [SW-1:0] trial;

        if (k == 0)
        begin : g_first
            assign prev = sq_in;
            assign pv   = !job_empty;
        end
        else
        begin : g_rest
            assign prev = sq_reg[k-1];
            assign pv   = sq_vld[k-1];
        end

        always_comb
        begin
            nxt   = prev;
            trial = (SW'(prev.root) << (B + 1)) + (SW'(1) << (2 * B));
            if (prev.rem >= trial)
            begin
                nxt.rem     = prev.rem - trial;
                nxt.root[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld[k] <= 1'b0;
            end
            else if (ben)
            begin
                sq_vld[k] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ben)
            begin
                sq_reg[k] <= nxt;
            end
        end
    end

    always_comb
    begin
        logic [QW-1:0]          q;
        logic signed [NUM_W-1:0] n;
        logic [NUM_W-1:0]       mag;
        q          = sq_reg[QW-1].root;
        dv_in.d    = {q, 1'b0};
        dv_in.half = QW'(((QW + 1)'(q) + (QW + 1)'(1)) >> 1);
        dv_in.ctrl = sq_reg[QW-1].ctrl;
        dv_in.quo  = '0;
        for (int i = 0; i < 3; i++)
        begin
            n = $signed(sq_reg[QW-1].num[i]);
            mag = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
            dv_in.rem[i] = (CW'(mag) << FRAC_BITS) + CW'(q);
            dv_in.ovf[i] = dv_in.rem[i] >= (CW'(dv_in.d) << QB);
            dv_in.sgn[i] = n[NUM_W-1] ^ sq_reg[QW-1].ctrl.neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld[0] <= 1'b0;
        end
        else if (ben)
        begin
            dv_vld[0] <= sq_vld[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            dv_reg[0] <= dv_in;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_dv
        localparam int B = QB - j;
        dv_t           nxt;
        logic [CW-1:0] t;

        always_comb
        begin
            nxt = dv_reg[j-1];
            t   = CW'(dv_reg[j-1].d) << B;
            for (int i = 0; i < 3; i++)
            begin
                if (dv_reg[j-1].rem[i] >= t)
                begin
                    nxt.rem[i]    = dv_reg[j-1].rem[i] - t;
                    nxt.quo[i][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld[j] <= 1'b0;
            end
            else if (ben)
            begin
                dv_vld[j] <= dv_vld[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ben)
            begin
                dv_reg[j] <= nxt;
            end
        end
    end

    assign last     = dv_reg[QB];
    assign res_push = ben && dv_vld[QB];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cv[i] = sat16(MW'(last.quo[i]), last.sgn[i], last.ovf[i]);
        end
        rv = sat16(MW'(last.half), last.ctrl.neg, 1'b0);
        res.handedness_flipped = last.ctrl.flip;
        res.invalid            = last.ctrl.bad;
        case (last.ctrl.slot)
            SLOT_X:
            begin
                res.quat_x = rv;    res.quat_y = cv[0];
                res.quat_z = cv[1]; res.quat_w = cv[2];
            end
            SLOT_Y:
            begin
                res.quat_x = cv[0]; res.quat_y = rv;
                res.quat_z = cv[1]; res.quat_w = cv[2];
            end
            SLOT_Z:
            begin
                res.quat_x = cv[0]; res.quat_y = cv[1];
                res.quat_z = rv;    res.quat_w = cv[2];
            end
            default:
            begin
                res.quat_x = cv[0]; res.quat_y = cv[1];
                res.quat_z = cv[2]; res.quat_w = rv;
            end
        endcase
        if (last.ctrl.bad)
        begin
            res.quat_x = '0;
            res.quat_y = '0;
            res.quat_z = '0;
            res.quat_w = '0;
        end
    end

endmodule

@@ hdl/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts the read, phase and slice direction vectors of an orientation
// matrix into a unit quaternion.
//
// Both sides behave as queues. A matrix word is taken at a clock edge with
// push high and full low; the oldest quaternion word is shown while empty is
// low and leaves at an edge with pop high.
// One word is accepted per cycle as long as results are popped. From push to
// empty going low a word passes 4 front stages, the middle queue,
// QW + QB + 1 back stages and the result queue, where QW is half the shifted
// radicand width rounded up (17 at FRAC_BITS 14) and QB is 17. The back
// pipeline finds one root bit or one quotient bit per stage.
// When pop stays low the back pipeline holds once the result queue is full,
// the middle queue then fills, and full rises when the front stages hold.
// Reset empties both queues and clears every stage valid flag.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  rmq_pkg::rmq_in_t   item,
    output logic               empty,
    input  logic               pop,
    output rmq_pkg::rmq_out_t  result
);
    import rmq_pkg::*;

    localparam int RAD_W = rad_width(FRAC_BITS);
    localparam int JW    = RAD_W + 3 * NUM_W + $bits(rmq_ctrl_t);
    localparam int OW    = $bits(rmq_out_t);

    logic                       f_push, f_full, b_pop, m_empty;
    logic signed [RAD_W-1:0]    f_rad, b_rad;
    logic [2:0][NUM_W-1:0]      f_num, b_num;
    rmq_ctrl_t                  f_ctrl, b_ctrl;
    logic [JW-1:0]              m_dout;
    logic                       r_push, r_full;
    rmq_out_t                   r_res;
    logic [OW-1:0]              o_dout;

    rmq_front #(.FRAC_BITS(FRAC_BITS), .RAD_W(RAD_W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .job_push (f_push),
        .job_full (f_full),
        .job_rad  (f_rad),
        .job_num  (f_num),
        .job_ctrl (f_ctrl)
    );

    rmq_fifo #(.WIDTH(JW), .DEPTH(MID_DEPTH)) u_mid (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .din   ({f_rad, f_num, f_ctrl}),
        .full  (f_full),
        .pop   (b_pop),
        .dout  (m_dout),
        .empty (m_empty)
    );

    assign {b_rad, b_num, b_ctrl} = m_dout;

    rmq_back #(.FRAC_BITS(FRAC_BITS), .RAD_W(RAD_W)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (m_empty),
        .job_pop   (b_pop),
        .job_rad   (b_rad),
        .job_num   (b_num),
        .job_ctrl  (b_ctrl),
        .res_push  (r_push),
        .res_full  (r_full),
        .res       (r_res)
    );

    rmq_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_push),
        .din   (r_res),
        .full  (r_full),
        .pop   (pop),
        .dout  (o_dout),
        .empty (empty)
    );

    assign result = o_dout;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for rotation_matrix_to_quaternion. Matrix words are pushed with
// random gaps and quaternion words popped with random stalls. A scoreboard
// predicts each quaternion in fixed point and checks every popped word
// against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import rmq_pkg::*;

    localparam int FB = 14;
    localparam int LATENCY = 41;
    localparam int WATCHDOG_LIMIT = 20000;

    class quat_scoreboard;
        rmq_out_t quat_queue[$];
        int errors;

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function longint divide_root(longint n, longint unsigned q);
            longint unsigned mag;
            longint unsigned r;
            mag = longint'(n < 0 ? -n : n) << (FB - 1);
            r = (2 * mag + q) / (2 * q);
            return n < 0 ? -longint'(r) : longint'(r);
        endfunction

        function logic signed [15:0] clamp(longint v);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function void note_matrix(rmq_in_t m);
            longint one, r11, r21, r31, r12, r22, r32, r13, r23, r33;
            longint det, t, rad, qx, qy, qz, qw;
            longint unsigned q;
            logic flip, bad, neg;
            rmq_out_t e;
            one = longint'(1) << FB;
            r11 = longint'(m.read_x);  r21 = longint'(m.read_y);
            r31 = longint'(m.read_z);
            r12 = longint'(m.phase_x); r22 = longint'(m.phase_y);
            r32 = longint'(m.phase_z);
            r13 = longint'(m.slice_x); r23 = longint'(m.slice_y);
            r33 = longint'(m.slice_z);
            qx = 0; qy = 0; qz = 0; qw = 0;
            bad = 1'b0; neg = 1'b0;
            det = r11 * r22 * r33 + r12 * r23 * r31 + r21 * r32 * r13
                - r13 * r22 * r31 - r12 * r21 * r33 - r11 * r23 * r32;
            flip = det < 0;
            if (flip)
            begin
                r13 = -r13; r23 = -r23; r33 = -r33;
            end
            t = one + r11 + r22 + r33;
            if (100000 * t > one)
            begin
                q = isqrt(longint'(t) << FB);
                qx = divide_root(r32 - r23, q);
                qy = divide_root(r13 - r31, q);
                qz = divide_root(r21 - r12, q);
                qw = longint'((q + 1) >> 1);
            end
            else
            begin
                if (r11 - r22 - r33 > 0)
                begin
                    rad = one + r11 - r22 - r33;
                    q = isqrt(longint'(rad) << FB);
                    qx = longint'((q + 1) >> 1);
                    qy = divide_root(r21 + r12, q);
                    qz = divide_root(r31 + r13, q);
                    qw = divide_root(r32 - r23, q);
                end
                else if (r22 - r11 - r33 > 0)
                begin
                    rad = one + r22 - r11 - r33;
                    q = isqrt(longint'(rad) << FB);
                    qx = divide_root(r21 + r12, q);
                    qy = longint'((q + 1) >> 1);
                    qz = divide_root(r32 + r23, q);
                    qw = divide_root(r13 - r31, q);
                    neg = (r21 + r12) < 0;
                end
                else
                begin
                    rad = one + r33 - r11 - r22;
                    if (rad <= 0)
                        bad = 1'b1;
                    else
                    begin
                        q = isqrt(longint'(rad) << FB);
                        qx = divide_root(r13 + r31, q);
                        qy = divide_root(r23 + r32, q);
                        qz = longint'((q + 1) >> 1);
                        qw = divide_root(r21 - r12, q);
                        neg = (r13 + r31) < 0;
                    end
                end
                if (neg)
                begin
                    qx = -qx; qy = -qy; qz = -qz; qw = -qw;
                end
            end
            e.quat_x = clamp(qx);
            e.quat_y = clamp(qy);
            e.quat_z = clamp(qz);
            e.quat_w = clamp(qw);
            e.handedness_flipped = flip;
            e.invalid = bad;
            quat_queue.push_back(e);
        endfunction

        function void check_quat(rmq_out_t got);
            rmq_out_t e;
            if (quat_queue.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word %h", got);
                return;
            end
            e = quat_queue.pop_front();
            if (got.quat_x !== e.quat_x || got.quat_y !== e.quat_y ||
                got.quat_z !== e.quat_z || got.quat_w !== e.quat_w ||
                got.handedness_flipped !== e.handedness_flipped ||
                got.invalid !== e.invalid)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected x %0d y %0d z %0d w %0d f %b i %b,",
                              " got x %0d y %0d z %0d w %0d f %b i %b"},
                        e.quat_x, e.quat_y, e.quat_z, e.quat_w,
                        e.handedness_flipped, e.invalid,
                        got.quat_x, got.quat_y, got.quat_z, got.quat_w,
                        got.handedness_flipped, got.invalid);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    rmq_in_t item;
    logic empty;
    logic pop;
    rmq_out_t result;

    quat_scoreboard sb;
    bit calm;
    bit stimulus_done;
    int idle_cycles;

    rotation_matrix_to_quaternion DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [15:0] rand_comp();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'sh8000;
        if (k == 1) return 16'sh7fff;
        if (k < 4) return 16'($urandom_range(0, 65535));
        return 16'($signed($urandom_range(0, 8192)) - 16'sd4096 +
            ($urandom_range(0, 2) == 0 ? 16'sd0 :
             ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)));
    endfunction

    function automatic logic signed [15:0] nz(logic signed [15:0] v);
        return v + $signed(16'($urandom_range(0, 40))) - 16'sd20;
    endfunction

    function automatic rmq_in_t random_matrix();
        rmq_in_t m;
        logic signed [15:0] p;
        int k;
        int sel [3];
        int sg [3];
        int i;
        k = $urandom_range(0, 3);
        if (k == 0)
        begin
            m.read_x = rand_comp(); m.read_y = rand_comp(); m.read_z = rand_comp();
            m.phase_x = rand_comp(); m.phase_y = rand_comp(); m.phase_z = rand_comp();
            m.slice_x = rand_comp(); m.slice_y = rand_comp(); m.slice_z = rand_comp();
            return m;
        end
        sel[0] = $urandom_range(0, 2);
        sel[1] = (sel[0] + 1 + $urandom_range(0, 1)) % 3;
        sel[2] = 3 - sel[0] - sel[1];
        for (i = 0; i < 3; i++) sg[i] = $urandom_range(0, 1);
        m = '0;
        p = 16'sd16384;
        for (i = 0; i < 3; i++)
        begin
            logic signed [15:0] v;
            v = nz(sg[i] ? -p : p);
            case (i * 3 + sel[i])
                0: m.read_x = v; 1: m.read_y = v; 2: m.read_z = v;
                3: m.phase_x = v; 4: m.phase_y = v; 5: m.phase_z = v;
                6: m.slice_x = v; 7: m.slice_y = v; default: m.slice_z = v;
            endcase
        end
        if (k == 3)
        begin
            m.read_y = m.read_y + 16'($urandom_range(0, 600)) - 16'sd300;
            m.phase_z = m.phase_z + 16'($urandom_range(0, 600)) - 16'sd300;
            m.slice_x = m.slice_x + 16'($urandom_range(0, 600)) - 16'sd300;
        end
        return m;
    endfunction

    function automatic rmq_in_t mk(int a, int b, int c, int d, int e, int f,
                                   int g, int h, int j);
        rmq_in_t m;
        m.read_x = 16'(a); m.read_y = 16'(b); m.read_z = 16'(c);
        m.phase_x = 16'(d); m.phase_y = 16'(e); m.phase_z = 16'(f);
        m.slice_x = 16'(g); m.slice_y = 16'(h); m.slice_z = 16'(j);
        return m;
    endfunction

    task automatic send_matrix(rmq_in_t m);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= m;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_matrix(m);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (sb.quat_queue.size() != 0 && guard < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    initial
    begin
        int n;
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        calm = 0;
        stimulus_done = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_matrix(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_matrix(mk(16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        send_matrix(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_matrix(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        send_matrix(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        send_matrix(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_matrix(mk(-16384, 100, 0, 100, -16384, 0, 0, 0, 16384));
        send_matrix(mk(-16384, -100, 0, -100, 16384, 0, 0, 0, -16384));
        send_matrix(mk(-16384, 0, -100, 0, -16384, 0, -100, 0, 16384));
        send_matrix(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 0));
        send_matrix(mk(-32768, 0, 0, 0, 0, 0, 0, 0, -32768));
        send_matrix(mk(-8192, 0, 0, 0, -8192, 0, 0, 0, 0));
        send_matrix(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_matrix(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                       -32768, -32768, -32768));
        send_matrix(mk(-16384, 32767, -32768, 32767, -16384, 32767, -32768, 32767, 16384));
        send_matrix(mk(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
        send_matrix(mk(-16383, 0, 0, 0, -1, 0, 0, 0, 0));
        drain_results();
        calm = 1;
        for (n = 0; n < 500; n++)
        begin
            if (n == 150) calm = 0;
            if (n == 300) drain_results();
            send_matrix(random_matrix());
        end
        push <= 1'b0;
        stimulus_done = 1;
    end

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty) sb.check_quat(result);
            pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
            if (stimulus_done && sb.quat_queue.size() == 0)
            begin
                repeat (2 * LATENCY) @(posedge clk);
                if (sb.errors == 0)
                    $display("tb OK");
                else
                    $display("tb NOT OK");
                $finish;
            end
        end
    end
endmodule
